FILE: src/lpx_pkg.sv
package lpx_pkg;

  localparam int HalfTapsDef = 127;
  localparam int ChannelsDef = 2;

  localparam int SampleW  = 24;
  localparam int CoefW    = 18;
  localparam int IdxW     = 7;
  localparam int InDataW  = 56;
  localparam int OutDataW = 80;

  localparam logic signed [CoefW-1:0] Unity = 18'sd65536;

  typedef enum logic {
    CMD_SAMPLE,
    CMD_COEF
  } cmd_e;

  typedef struct packed {
    cmd_e                      kind;
    logic                      channel;
    logic signed [SampleW-1:0] sample;
    logic                      filt;
    logic [IdxW-1:0]           idx;
    logic signed [CoefW-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } be_status_t;

endpackage

FILE: src/lpx_fifo.sv
module lpx_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lpx_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output lpx_pkg::cmd_t data_o
);
  import lpx_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: src/lpx_front.sv
module lpx_front #(
  parameter int HALF_TAPS = lpx_pkg::HalfTapsDef,
  parameter int CHANNELS  = lpx_pkg::ChannelsDef
) (
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic                         s_axis_tuser,
  input  logic [lpx_pkg::InDataW-1:0]  s_axis_tdata,
  input  lpx_pkg::be_status_t          status_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output lpx_pkg::cmd_t                cmd_o
);
  import lpx_pkg::*;

  logic accept;
  logic keep;

  assign s_axis_tready = !q_full_i && !status_i.clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd_o.kind    = s_axis_tuser ? CMD_COEF : CMD_SAMPLE;
    cmd_o.channel = s_axis_tdata[0];
    cmd_o.sample  = s_axis_tdata[24:1];
    cmd_o.filt    = s_axis_tdata[25];
    cmd_o.idx     = s_axis_tdata[32:26];
    cmd_o.value   = s_axis_tdata[50:33];
    if (s_axis_tuser) begin
      keep = (32'(s_axis_tdata[32:26]) <= 32'(HALF_TAPS));
    end else begin
      keep = (32'(s_axis_tdata[0]) < 32'(CHANNELS));
    end
  end

  assign push_o = accept && keep;

endmodule

FILE: src/lpx_back.sv
module lpx_back #(
  parameter int HALF_TAPS = lpx_pkg::HalfTapsDef,
  parameter int CHANNELS  = lpx_pkg::ChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  lpx_pkg::cmd_t                cmd_i,
  output logic                         pop_o,
  output lpx_pkg::be_status_t          status_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [lpx_pkg::OutDataW-1:0] m_axis_tdata
);
  import lpx_pkg::*;

  localparam int Taps   = 2 * HALF_TAPS + 1;
  localparam int PW     = $clog2(Taps);
  localparam int HDepth = CHANNELS * Taps;
  localparam int HAW    = $clog2(HDepth);
  localparam int IW     = $clog2(HALF_TAPS + 1);
  localparam int CDepth = 2 * (2 ** IW);
  localparam int CAW    = IW + 1;
  localparam int ClrN   = (HDepth > CDepth) ? HDepth : CDepth;
  localparam int CLW    = $clog2(ClrN);
  localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ProdW  = SampleW + 1 + CoefW;
  localparam int AccW   = ProdW + IW + 1;
  localparam int LpW    = AccW - 16;
  localparam int DW     = LpW + 1;
  localparam logic signed [DW-1:0] SatMax = DW'(8388607);
  localparam logic signed [DW-1:0] SatMin = -DW'(8388608);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic filt;
  } tag_t;

  function automatic logic signed [SampleW-1:0] sat24(input logic signed [DW-1:0] v);
    logic signed [SampleW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[SampleW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[SampleW-1:0];
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

  logic signed [SampleW-1:0] hist_mem [HDepth];
  logic signed [CoefW-1:0]   coef_mem [CDepth];

  state_e                    state_q;
  logic [CLW-1:0]            clr_q;
  logic [PW-1:0]             wp_q [CHANNELS];
  logic [HAW-1:0]            base_q;
  logic                      ch_q;
  logic [PW-1:0]             a_q, b_q, w_q;
  logic [IW-1:0]             t_q;
  logic                      f_q;
  tag_t                      t1_q, t2_q;
  logic signed [SampleW-1:0] rda_q, rdb_q, delayed_q;
  logic signed [CoefW-1:0]   coef_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    acc_q, acc1_q, acc2_q;
  logic signed [LpW-1:0]     lp1_q, lp2_q;
  logic                      out_valid_q;
  logic [OutDataW-1:0]       out_data_q;

  logic [CHW-1:0]            ch_idx;
  logic [PW-1:0]             w_cur;
  logic [HAW-1:0]            base_cur;
  logic                      hist_we, coef_we;
  logic [HAW-1:0]            hist_wa, hist_ra, hist_rb;
  logic signed [SampleW-1:0] hist_wd;
  logic [CAW-1:0]            coef_wa, coef_ra;
  logic signed [CoefW-1:0]   coef_wd;
  logic                      t_end;
  logic signed [SampleW:0]   pair_sum;
  logic signed [AccW-1:0]    acc_d, rnd1, rnd2;
  logic                      out_free;

  assign ch_idx   = CHW'(cmd_i.channel);
  assign w_cur    = wp_q[ch_idx];
  assign base_cur = HAW'(ch_idx) * HAW'(Taps);
  assign pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign status_o.clearing = (state_q == ST_CLEAR);
  assign t_end    = (t_q == IW'(HALF_TAPS));
  assign hist_ra  = base_q + HAW'(a_q);
  assign hist_rb  = base_q + HAW'(b_q);
  assign coef_ra  = {f_q, t_q};
  assign pair_sum = (SampleW+1)'(rda_q) + (t1_q.last ? '0 : (SampleW+1)'(rdb_q));
  assign acc_d    = (t2_q.first ? '0 : acc_q) + AccW'(prod_q);
  assign rnd1     = acc1_q + AccW'(32768);
  assign rnd2     = acc2_q + AccW'(32768);
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    hist_we = 1'b0;
    hist_wa = base_cur + HAW'(w_cur);
    hist_wd = cmd_i.sample;
    coef_we = 1'b0;
    coef_wa = {cmd_i.filt, IW'(cmd_i.idx)};
    coef_wd = cmd_i.value;
    if (state_q == ST_CLEAR) begin
      hist_we = (32'(clr_q) < HDepth);
      hist_wa = HAW'(clr_q);
      hist_wd = '0;
      coef_we = (32'(clr_q) < CDepth);
      coef_wa = CAW'(clr_q);
      coef_wd = (CAW'(clr_q) % CAW'(2 ** IW) == CAW'(HALF_TAPS)) ? Unity : '0;
    end else if (pop_o) begin
      hist_we = (cmd_i.kind == CMD_SAMPLE);
      coef_we = (cmd_i.kind == CMD_COEF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    rda_q <= hist_mem[hist_ra];
    rdb_q <= hist_mem[hist_rb];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_q <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_q[i] <= '0;
      end
      t1_q        <= '0;
      t2_q        <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      ch_q        <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      w_q         <= '0;
      t_q         <= '0;
      f_q         <= 1'b0;
      delayed_q   <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      acc1_q      <= '0;
      acc2_q      <= '0;
      lp1_q       <= '0;
      lp2_q       <= '0;
      out_data_q  <= '0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      t1_q   <= '{valid: (state_q == ST_RUN), first: (t_q == '0), last: t_end, filt: f_q};
      t2_q   <= t1_q;
      prod_q <= coef_q * pair_sum;
      if (t1_q.valid && t1_q.last) begin
        delayed_q <= rda_q;
      end
      if (t2_q.valid) begin
        acc_q <= acc_d;
        if (t2_q.last && !t2_q.filt) begin
          acc1_q <= acc_d;
        end
        if (t2_q.last && t2_q.filt) begin
          acc2_q <= acc_d;
        end
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == ClrN - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i && cmd_i.kind == CMD_SAMPLE) begin
            base_q       <= base_cur;
            ch_q         <= cmd_i.channel;
            w_q          <= w_cur;
            a_q          <= w_cur;
            b_q          <= (32'(w_cur) == Taps - 1) ? '0 : w_cur + 1'b1;
            t_q          <= '0;
            f_q          <= 1'b0;
            wp_q[ch_idx] <= (32'(w_cur) == Taps - 1) ? '0 : w_cur + 1'b1;
            state_q      <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (t_end) begin
            t_q <= '0;
            a_q <= w_q;
            b_q <= (32'(w_q) == Taps - 1) ? '0 : w_q + 1'b1;
            f_q <= 1'b1;
            if (f_q) begin
              state_q <= ST_DRAIN;
            end
          end else begin
            t_q <= t_q + 1'b1;
            a_q <= (a_q == '0) ? PW'(Taps - 1) : a_q - 1'b1;
            b_q <= (32'(b_q) == Taps - 1) ? '0 : b_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (t2_q.valid && t2_q.last && t2_q.filt) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          lp1_q   <= rnd1[AccW-1:16];
          lp2_q   <= rnd2[AccW-1:16];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_data_q  <= OutDataW'({
              sat24(DW'(delayed_q) - DW'(lp2_q)),
              sat24(DW'(lp2_q) - DW'(lp1_q)),
              sat24(DW'(lp1_q)),
              ch_q});
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_tag_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t1_q.valid |=> t2_q.valid)
    else $error("tap pipeline lost a step");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !pop_o)
    else $error("queue popped during clearing pass");
  a_tag_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t2_q.valid |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("accumulate outside a filter run");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result loaded outside output state");
`endif

endmodule

FILE: src/linear_phase_three_band_crossover_unit.sv
// Sample transaction: the filter engine takes one sample at a time and returns its bands.
// A single shared multiply-accumulate walks both filters' tap pairs for each sample.
// Coefficient writes are applied in the engine's idle state; a two-entry queue buffers the input.
// After reset a clearing pass zeroes history and loads passthrough coefficients; no input is taken.
module linear_phase_three_band_crossover_unit #(
  parameter int HALF_TAPS = lpx_pkg::HalfTapsDef,
  parameter int CHANNELS  = lpx_pkg::ChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic                         s_axis_tuser,  // func
  // channel, sample, coef_filter, coef_index, coef_value
  input  logic [lpx_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_channel, low_band, mid_band, high_band
  output logic [lpx_pkg::OutDataW-1:0] m_axis_tdata
);
  import lpx_pkg::*;

  be_status_t status;
  cmd_t       push_cmd, pop_cmd;
  logic       push, q_full, q_valid, pop;

  lpx_front #(.HALF_TAPS(HALF_TAPS), .CHANNELS(CHANNELS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .status_i      (status),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  lpx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (pop_cmd)
  );

  lpx_back #(.HALF_TAPS(HALF_TAPS), .CHANNELS(CHANNELS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: tb/tb_linear_phase_three_band_crossover_unit.sv
`timescale 1ns / 1ps

module tb_linear_phase_three_band_crossover_unit;
  import lpx_pkg::*;

  localparam int HalfTaps = HalfTapsDef;
  localparam int Taps     = 2 * HalfTaps + 1;
  localparam int Chans    = ChannelsDef;

  typedef struct packed {
    logic signed [SampleW-1:0] high_band;
    logic signed [SampleW-1:0] mid_band;
    logic signed [SampleW-1:0] low_band;
    logic                      channel;
  } bands_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic                s_axis_tuser;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  linear_phase_three_band_crossover_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  logic signed [SampleW-1:0] history [Chans][Taps];
  int                        wr_pos  [Chans];
  logic signed [CoefW-1:0]   coefs   [2][HalfTaps+1];
  bands_t                    expected_bands [$];
  bit                        failed;
  bit                        steady;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("linear_phase_three_band_crossover_unit verification failed");
    $finish;
  end

  function automatic longint filter_out(int ch, int w, int f);
    longint acc;
    int     a;
    int     b;
    acc = longint'(coefs[f][HalfTaps]) * longint'(history[ch][(w + Taps - HalfTaps) % Taps]);
    for (int t = 0; t < HalfTaps; t++) begin
      a = (w + Taps - t) % Taps;
      b = (w + 1 + t) % Taps;
      acc += longint'(coefs[f][t]) * (longint'(history[ch][a]) + longint'(history[ch][b]));
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic logic signed [SampleW-1:0] clip24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[SampleW-1:0];
  endfunction

  function automatic void predict_crossover(cmd_e kind, logic ch, logic signed [SampleW-1:0] smp,
                                            logic filt, logic [IdxW-1:0] idx,
                                            logic signed [CoefW-1:0] val);
    int     w;
    longint lp1;
    longint lp2;
    longint delayed;
    bands_t r;
    if (kind == CMD_COEF) begin
      if (idx <= HalfTaps) coefs[filt][idx] = val;
      return;
    end
    w = wr_pos[ch];
    history[ch][w] = smp;
    lp1 = filter_out(ch, w, 0);
    lp2 = filter_out(ch, w, 1);
    delayed = history[ch][(w + Taps - HalfTaps) % Taps];
    wr_pos[ch] = (w + 1) % Taps;
    r.channel   = ch;
    r.low_band  = clip24(lp1);
    r.mid_band  = clip24(lp2 - lp1);
    r.high_band = clip24(delayed - lp2);
    expected_bands.push_back(r);
  endfunction

  task automatic send_item(cmd_e kind, logic ch, logic signed [SampleW-1:0] smp, logic filt,
                           logic [IdxW-1:0] idx, logic signed [CoefW-1:0] val);
    if (!steady && $urandom_range(99) < 20) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tuser  = kind;
    s_axis_tdata  = {5'b0, val, idx, filt, smp, ch};
    s_axis_tvalid = 1'b1;
    #1;
    while (!s_axis_tready) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    predict_crossover(kind, ch, smp, filt, idx, val);
    @(negedge clk_i);
  endtask

  task automatic send_sample(logic ch, logic signed [SampleW-1:0] smp);
    send_item(CMD_SAMPLE, ch, smp, 1'b0, '0, '0);
  endtask

  task automatic send_coef(logic filt, logic [IdxW-1:0] idx, logic signed [CoefW-1:0] val);
    send_item(CMD_COEF, 1'($urandom_range(1)), SampleW'($urandom), filt, idx, val);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin
    bands_t got;
    bands_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[72:0];
      if (expected_bands.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        exp_r = expected_bands.pop_front();
        if (got.channel !== exp_r.channel) begin
          $display("%0t: channel expected %0d actual %0d", $time, exp_r.channel, got.channel);
          failed = 1'b1;
        end
        if (got.low_band !== exp_r.low_band) begin
          $display("%0t: low expected %0d actual %0d", $time, exp_r.low_band, got.low_band);
          failed = 1'b1;
        end
        if (got.mid_band !== exp_r.mid_band) begin
          $display("%0t: mid expected %0d actual %0d", $time, exp_r.mid_band, got.mid_band);
          failed = 1'b1;
        end
        if (got.high_band !== exp_r.high_band) begin
          $display("%0t: high expected %0d actual %0d", $time, exp_r.high_band, got.high_band);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic test_passthrough();
    send_sample(1'b0, 24'sh7FFFFF);
    send_sample(1'b1, 24'sh800000);
    send_sample(1'b0, 24'sh000001);
    send_sample(1'b1, 24'shFFFFFF);
  endtask

  task automatic test_coef_extremes();
    send_coef(1'b0, 7'd0, 18'sh1FFFF);
    send_coef(1'b1, 7'd0, 18'sh20000);
    send_coef(1'b0, IdxW'(HalfTaps), 18'sh20000);
    send_coef(1'b1, IdxW'(HalfTaps), 18'sh1FFFF);
    send_coef(1'b0, 7'd63, 18'sh08000);
    send_coef(1'b1, 7'd1, 18'sh3FFFF);
    send_sample(1'b0, 24'sh7FFFFF);
    send_sample(1'b0, 24'sh800000);
    send_sample(1'b1, 24'sh7FFFFF);
    send_sample(1'b1, 24'sh000000);
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 6; i++) send_sample(i[0], (i & 2) ? 24'sh800000 : 24'sh7FFFFF);
    send_coef(1'b0, 7'd0, 18'sh0);
    send_coef(1'b1, IdxW'(HalfTaps), 18'sh10000);
  endtask

  task automatic test_random(int count);
    logic signed [CoefW-1:0] val;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3) && (i < count / 3 + 250);
      if ($urandom_range(99) < 10) begin
        val = ($urandom_range(99) < 70) ? CoefW'($signed($urandom_range(16384)) - 8192)
                                        : CoefW'($urandom);
        send_coef(1'($urandom_range(1)), IdxW'($urandom_range(HalfTaps)), val);
      end else begin
        send_sample(1'($urandom_range(1)), SampleW'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    failed = 1'b0;
    steady = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    for (int c = 0; c < Chans; c++) begin
      wr_pos[c] = 0;
      for (int t = 0; t < Taps; t++) history[c][t] = '0;
    end
    for (int f = 0; f < 2; f++)
      for (int t = 0; t <= HalfTaps; t++) coefs[f][t] = (t == HalfTaps) ? Unity : '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_passthrough();
    test_coef_extremes();
    test_saturation();
    test_random(1530);
    s_axis_tvalid = 1'b0;
    while (expected_bands.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (!failed) begin
      $display("linear_phase_three_band_crossover_unit verification clean");
    end else begin
      $display("linear_phase_three_band_crossover_unit verification failed");
    end
    $finish;
  end

endmodule
